### hdl/sev_pkg.sv
package sev_pkg;

	// Default operand stack depth
	localparam int STACK_DEPTH_DEF = 16;

	// Command queue between front and back
	localparam int FIFO_DEPTH = 2;

	// One quotient bit per divider step
	localparam int DIV_STEPS = 32;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNDER   = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_OVER    = 2'd3;

	// Command kinds produced by the front decoder
	localparam logic [2:0] KIND_IGNORE = 3'd0;
	localparam logic [2:0] KIND_DIGIT  = 3'd1;
	localparam logic [2:0] KIND_ADD    = 3'd2;
	localparam logic [2:0] KIND_SUB    = 3'd3;
	localparam logic [2:0] KIND_MUL    = 3'd4;
	localparam logic [2:0] KIND_DIV    = 3'd5;

	// Decoded command: kind, digit value, end-of-expression mark, notation
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] digit;
		logic       last;
		logic       mode;
	} cmd_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

### hdl/sev_front.sv
module sev_front
	import sev_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       full,
	output logic       push,
	output cmd_t       cmd
);

	logic       mode_q;
	logic [7:0] digit_off;

	// Notation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Item accepted whenever the queue has room
	assign in_stall = full;
	assign push     = in_valid && !full;

	// Classify the character
	assign digit_off = char_code - CH_ZERO;

	always_comb begin
		cmd.digit = digit_off[3:0];
		cmd.last  = last_char;
		cmd.mode  = mode_q;
		case (char_code) inside
			[CH_ZERO:CH_NINE]: cmd.kind = KIND_DIGIT;
			CH_PLUS:           cmd.kind = KIND_ADD;
			CH_MINUS:          cmd.kind = KIND_SUB;
			CH_STAR:           cmd.kind = KIND_MUL;
			CH_SLASH:          cmd.kind = KIND_DIV;
			default:           cmd.kind = KIND_IGNORE;
		endcase
	end

endmodule

### hdl/sev_fifo.sv
module sev_fifo
	import sev_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output cmd_t q_cmd
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	cmd_t          entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full    = (fill_q == CW'(FIFO_DEPTH));
	assign q_valid = (fill_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### hdl/sev_div.sv
module sev_div
	import sev_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int SW = $clog2(DIV_STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic          neg_q;
	logic [31:0]   rem_q;
	logic [31:0]   quo_q;
	logic [31:0]   dvs_q;
	logic [32:0]   shifted;
	logic [32:0]   diff;
	logic          fits;

	// Restoring step: one quotient bit per cycle
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = !diff[32];

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(DIV_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + SW'(1);
				end
			end
		end
	end

	// Datapath on magnitudes, sign applied at the end
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[31] ^ req.divisor[31];
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dvs_q <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
		end else if (busy_q) begin
			if (step_q == SW'(DIV_STEPS)) begin
				quo_q <= neg_q ? (32'd0 - quo_q) : quo_q;
			end else begin
				rem_q <= fits ? diff[31:0] : shifted[31:0];
				quo_q <= {quo_q[30:0], fits};
			end
		end
	end

endmodule

### hdl/sev_back.sv
module sev_back
	import sev_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic [1:0]  status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIVW = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	// Entries below the top; the top lives in top_q
	logic [31:0]   mem [STACK_DEPTH];
	logic [31:0]   rdata_q;
	logic [31:0]   top_q;
	cmd_t          cmd_q;
	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [1:0]    err_q;
	logic [1:0]    err_d;
	logic          out_valid_q;
	logic [31:0]   value_q;
	logic [1:0]    status_q;
	logic          top_we;
	logic [31:0]   top_d;
	logic          mem_we;
	logic          mem_rd;
	logic          out_load;
	logic [31:0]   lhs;
	logic [31:0]   rhs;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);

	// Operand order follows the notation captured with the item
	assign lhs = cmd_q.mode ? top_q : rdata_q;
	assign rhs = cmd_q.mode ? rdata_q : top_q;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// Sequencer
	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		err_d            = err_q;
		pop              = 1'b0;
		top_we           = 1'b0;
		top_d            = top_q;
		mem_we           = 1'b0;
		mem_rd           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = lhs;
		div_req.divisor  = rhs;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = q_cmd.last ? S_OUT : S_IDLE;
					case (q_cmd.kind)
						KIND_DIGIT: begin
							if (count_q >= CW'(STACK_DEPTH)) begin
								if (err_q == ST_OK) err_d = ST_OVER;
							end else begin
								mem_we  = (count_q != '0);
								top_we  = 1'b1;
								top_d   = {28'd0, q_cmd.digit};
								count_d = count_q + CW'(1);
							end
						end
						KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
							if (count_q < CW'(2)) begin
								if (err_q == ST_OK) err_d = ST_UNDER;
							end else begin
								mem_rd  = 1'b1;
								state_d = S_EXEC;
							end
						end
						default: ;
					endcase
				end
			end
			S_EXEC: begin
				state_d = cmd_q.last ? S_OUT : S_IDLE;
				case (cmd_q.kind)
					KIND_ADD: begin
						top_we  = 1'b1;
						top_d   = lhs + rhs;
						count_d = cnt_m1;
					end
					KIND_SUB: begin
						top_we  = 1'b1;
						top_d   = lhs - rhs;
						count_d = cnt_m1;
					end
					KIND_MUL: begin
						top_we  = 1'b1;
						top_d   = lhs * rhs;
						count_d = cnt_m1;
					end
					KIND_DIV: begin
						if (rhs == '0) begin
							if (err_q == ST_OK) err_d = ST_DIVZERO;
						end else begin
							div_req.start = 1'b1;
							state_d       = S_DIVW;
						end
					end
					default: ;
				endcase
			end
			S_DIVW: begin
				if (div_rsp.done) begin
					top_we  = 1'b1;
					top_d   = div_rsp.quotient;
					count_d = cnt_m1;
					state_d = cmd_q.last ? S_OUT : S_IDLE;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					count_d  = '0;
					err_d    = ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stack memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_m1[AW-1:0]] <= top_q;
		end
		if (mem_rd) begin
			rdata_q <= mem[cnt_m2[AW-1:0]];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (top_we) begin
			top_q <= top_d;
		end
		if (out_load) begin
			value_q  <= (count_q != '0) ? top_q : 32'd0;
			status_q <= (count_q == '0 && err_q == ST_OK) ? ST_UNDER : err_q;
		end
	end

endmodule

### hdl/stack_expression_evaluator.sv
// Stack expression evaluator.
// Input channel (in_valid / in_stall): one expression character per item in
// char_code, with last_char marking the final one. Digits push, '+' '-' '*'
// '/' combine the two top values, other bytes are ignored.
// Output channel (out_valid / out_stall): one item per expression, value is
// the top of the stack and status is ok, underflow/empty, divide by zero or
// overflow (first error of the expression wins).
// notation_mode is written through cfg_we / cfg_wdata; the user must write it
// only while the block idles; the block itself does not enforce this.
// 0 postfix, 1 prefix with characters fed last to first.
// A small command queue separates the decoder from the stack engine. A digit
// or ignored byte is handled in S_IDLE, '+' '-' '*' also pass S_EXEC, '/' then
// waits in S_DIVW as the divider retires one quotient bit per cycle, and the
// last character ends in S_OUT, which loads the output register.
// While out_stall holds, the result stays in the output register; later
// characters keep being processed until the next result needs that register.
// Reset empties the queue, the stack and the error, and sets postfix mode.
module stack_expression_evaluator
	import sev_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic [1:0]  status
);

	logic     push;
	logic     full;
	logic     pop;
	logic     q_valid;
	cmd_t     push_cmd;
	cmd_t     q_cmd;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Decode
	sev_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.full      (full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Command queue
	sev_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	// Stack engine
	sev_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	// Iterative divider
	sev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### hdl/sev_checker.sv
module sev_checker
	import sev_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value,
	input logic [1:0]  status
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
		else $error("result changed while stalled");

	// No result right out of reset
	a_rst_out: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// Queue is empty after reset, so input is taken
	a_rst_in: assert property (@(posedge clk) $rose(arst_n) |-> !in_stall)
		else $error("input stalled right after reset");

	// Input only starts stalling right after an item was taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stalled with no item taken");

endmodule

bind stack_expression_evaluator sev_checker u_sev_checker (.*);

### test/tb_stack_expression_evaluator.sv
`timescale 1ns / 1ps

module tb_stack_expression_evaluator;
	import sev_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 150;
	localparam int RAND_ITEMS   = 600;
	localparam int RAND_PHASES  = 6;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} expr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = 8'd0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic [1:0]  status;

	// Predictor state: operand stack, depth, first error, notation
	logic [31:0]  ev_stack [STACK_DEPTH_DEF];
	int           ev_depth = 0;
	logic [1:0]   ev_err = ST_OK;
	logic         ev_mode = 1'b0;
	expr_result_t pending_results [$];

	logic [7:0] expr_buf [$];
	bit         no_idle = 1'b0;
	int         rx_hold_req = 0;
	int         stall_left = 0;
	int         fail_count = 0;
	int         results_checked = 0;
	int         status_seen [4] = '{0, 0, 0, 0};
	int         chars_sent = 0;
	int         items_sent = 0;

	stack_expression_evaluator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Digits and operators; every other byte is dropped by the block
	function automatic bit is_item(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
			c == CH_STAR || c == CH_SLASH;
	endfunction

	function automatic void record_error(input logic [1:0] code);
		if (ev_err == ST_OK)
			ev_err = code;
	endfunction

	// Apply one character to the predicted stack; returns 1 when it ends an expression
	function automatic bit evaluate_char(input logic [7:0] c, input logic lst,
			output expr_result_t r);
		logic [31:0] top, nxt, lhs, rhs, res;
		longint      sl, sr, q;
		bit          ok;
		r = '0;
		res = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (ev_depth >= STACK_DEPTH_DEF) begin
				record_error(ST_OVER);
			end else begin
				ev_stack[ev_depth] = 32'(c - CH_ZERO);
				ev_depth++;
			end
		end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
			if (ev_depth < 2) begin
				record_error(ST_UNDER);
			end else begin
				top = ev_stack[ev_depth - 1];
				nxt = ev_stack[ev_depth - 2];
				// prefix pops the left operand first
				lhs = ev_mode ? top : nxt;
				rhs = ev_mode ? nxt : top;
				ok = 1'b1;
				if (c == CH_PLUS) begin
					res = lhs + rhs;
				end else if (c == CH_MINUS) begin
					res = lhs - rhs;
				end else if (c == CH_STAR) begin
					res = lhs * rhs;
				end else if (rhs == 32'd0) begin
					record_error(ST_DIVZERO);
					ok = 1'b0;
				end else begin
					// 64-bit quotient so most-negative / -1 wraps cleanly
					sl = $signed(lhs);
					sr = $signed(rhs);
					q = sl / sr;
					res = q[31:0];
				end
				if (ok) begin
					ev_depth--;
					ev_stack[ev_depth - 1] = res;
				end
			end
		end
		if (!lst)
			return 1'b0;
		if (ev_depth > 0) begin
			r.value = ev_stack[ev_depth - 1];
			r.status = ev_err;
		end else begin
			r.value = 32'd0;
			r.status = (ev_err != ST_OK) ? ev_err : ST_UNDER;
		end
		ev_depth = 0;
		ev_err = ST_OK;
		return 1'b1;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Send one item; returns right after the accepting edge
	task automatic send_char(input logic [7:0] c, input logic lst);
		int           gap;
		expr_result_t r;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
		if (is_item(c))
			items_sent++;
		if (evaluate_char(c, lst, r))
			pending_results.push_back(r);
	endtask

	task automatic send_buf(input bit mark_last);
		for (int i = 0; i < expr_buf.size(); i++)
			send_char(expr_buf[i], mark_last && (i == expr_buf.size() - 1));
	endtask

	task automatic send_text(input string s, input bit mark_last);
		expr_buf.delete();
		for (int i = 0; i < s.len(); i++)
			expr_buf.push_back(s[i]);
		send_buf(mark_last);
	endtask

	// Drop valid, wait for every result, then let the engine finish trailing work
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_notation(input logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		ev_mode = m;
	endtask

	// Random expression: mostly well formed, some broken, overflowing or raw bytes
	task automatic build_random_expr();
		int kind, depth, maxd, digits_left, ops_left;
		expr_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			maxd = $urandom_range(2, STACK_DEPTH_DEF);
			ops_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 5) :
				$urandom_range(6, 15);
			digits_left = ops_left + 1;
			depth = 0;
			while (digits_left + ops_left > 0) begin
				if ($urandom_range(0, 24) == 0)
					expr_buf.push_back(8'($urandom_range(0, 255)));
				if (digits_left > 0 && depth < maxd &&
						(depth < 2 || ops_left == 0 || $urandom_range(0, 1) == 1)) begin
					expr_buf.push_back(rand_digit());
					digits_left--;
					depth++;
				end else begin
					expr_buf.push_back(rand_op());
					ops_left--;
					depth--;
				end
			end
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 8))
				expr_buf.push_back(($urandom_range(0, 2) == 0) ? rand_op() : rand_digit());
		end else if (kind < 95) begin
			repeat ($urandom_range(STACK_DEPTH_DEF, STACK_DEPTH_DEF + 4))
				expr_buf.push_back(rand_digit());
			repeat ($urandom_range(0, 3))
				expr_buf.push_back(rand_op());
		end else begin
			repeat ($urandom_range(1, 6))
				expr_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_postfix_ops();
		set_notation(1'b0);
		send_text("0", 1'b1);
		send_text("9", 1'b1);
		send_text("34+", 1'b1);
		send_text("35-", 1'b1);
		send_text("98*", 1'b1);
		send_text("72/", 1'b1);
		send_text("07-2/", 1'b1);
		send_text("1 2", 1'b1);
	endtask

	task automatic test_error_cases();
		send_text("5+", 1'b1);
		send_text("+", 1'b1);
		send_text("50/", 1'b1);
		send_text("+50/", 1'b1);
		send_text("98765432109876543", 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
	endtask

	// Builds 2^31 (wraps to most negative), then divides by -1
	task automatic test_quotient_wrap();
		send_text("88*88**88*88***88*2**01-/", 1'b1);
	endtask

	task automatic test_prefix_ops();
		set_notation(1'b1);
		send_text("43-", 1'b1);
		send_text("27/", 1'b1);
		send_text("20/", 1'b1);
		send_text("02/", 1'b1);
		send_text("9 3*5+", 1'b1);
	endtask

	// Operands pushed in postfix, operator applied after switching to prefix
	task automatic test_mode_switch_mid_expr();
		set_notation(1'b0);
		send_text("84", 1'b0);
		set_notation(1'b1);
		send_text("-", 1'b1);
	endtask

	// Long receiver hold fills the block; then the sender waits for all results
	task automatic test_backpressure();
		set_notation(1'b0);
		rx_hold_req = HOLD_CYCLES;
		repeat (12) begin
			build_random_expr();
			send_buf(1'b1);
		end
		drain();
	endtask

	task automatic test_random_phases();
		int target;
		for (int p = 0; p < RAND_PHASES; p++) begin
			set_notation(p[0]);
			no_idle = (p == 3);
			target = chars_sent + RAND_ITEMS / RAND_PHASES;
			while (chars_sent < target) begin
				build_random_expr();
				send_buf(1'b1);
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end
		no_idle = 1'b0;
	endtask

	// Receiver stall pattern, with forced long holds on request
	always @(negedge clk) begin : rx_stall
		int n;
		if (rx_hold_req > 0) begin
			stall_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			n = pick_gap();
			out_stall <= (n > 0);
			stall_left = (n > 0) ? n - 1 : 0;
		end
	end

	// Compare each accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		expr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result: value %h status %0d", value, status);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				status_seen[want.status]++;
				if (value !== want.value) begin
					fail_count++;
					if (fail_count <= 10)
						$display("value mismatch: expected %h, got %h", want.value, value);
				end
				if (status !== want.status) begin
					fail_count++;
					if (fail_count <= 10)
						$display("status mismatch: expected %0d, got %0d", want.status, status);
				end
			end
		end
	end

	// Ends the run when neither channel moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_postfix_ops();
		test_error_cases();
		test_quotient_wrap();
		test_prefix_ops();
		test_mode_switch_mid_expr();
		test_backpressure();
		test_random_phases();
		drain();

		$display("Checked %0d results: ok %0d, underflow/empty %0d, div by zero %0d, overflow %0d",
			results_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		$display("Sent %0d characters (%0d digits/operators) in postfix and prefix notation",
			chars_sent, items_sent);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
hdl/sev_pkg.sv
hdl/sev_front.sv
hdl/sev_fifo.sv
hdl/sev_div.sv
hdl/sev_back.sv
hdl/stack_expression_evaluator.sv
hdl/sev_checker.sv
test/tb_stack_expression_evaluator.sv
